FILE: rtl/core/wcps_pkg.sv
`default_nettype none

package wcps_pkg;

   localparam int WIDTH_DEF       = 11;
   localparam int HEIGHT_DEF      = 10;
   localparam int MINUTE_DOTS_DEF = 4;

   localparam int ADDR_W = 5;
   localparam int PC_W   = 3;
   localparam int CNT_W  = 3;
   localparam int LEN_W  = 4;

   localparam logic [2:0] REG_COLOR_ON      = 3'd0;
   localparam logic [2:0] REG_COLOR_STARTUP = 3'd1;
   localparam logic [2:0] REG_COLOR_CONFIG  = 3'd2;
   localparam logic [2:0] REG_COLOR_ERROR   = 3'd3;
   localparam logic [2:0] REG_STATUS_FIRST  = 3'd4;
   localparam logic [2:0] REG_STATUS_COUNT  = 3'd5;

   localparam logic [1:0] FUNC_TIME   = 2'd0;
   localparam logic [1:0] FUNC_STATE  = 2'd1;
   localparam logic [1:0] FUNC_PIXEL  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_STARTUP = 2'd0;
   localparam logic [1:0] ST_CONFIG  = 2'd1;

   localparam logic [LEN_W-1:0] STARTUP_DOTS = 4'd1;
   localparam logic [LEN_W-1:0] CONFIG_DOTS  = 4'd2;
   localparam logic [LEN_W-1:0] MIN_DOTS     = 4'd2;
   localparam logic [LEN_W-1:0] MAX_DOTS     = 4'd8;

   localparam logic [PC_W-1:0] PC_TIME  = 3'd0;
   localparam logic [PC_W-1:0] PC_DOTS  = 3'd5;
   localparam logic [PC_W-1:0] PC_PIXEL = 3'd6;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_WORD,
      OP_HOUR,
      OP_DOTS,
      OP_PIXEL
   } op_type;

   typedef enum logic [1:0] {
      END_NEVER,
      END_NOHOUR,
      END_ALWAYS
   } endc_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] sel;
      endc_type   endc;
   } uword_type;

   typedef struct packed {
      logic [3:0]       x;
      logic [3:0]       y;
      logic [LEN_W-1:0] len;
   } span_type;

   typedef struct packed {
      logic [31:0] color_on;
      logic [31:0] color_startup;
      logic [31:0] color_config;
      logic [31:0] color_error;
      logic [7:0]  status_first;
      logic [3:0]  status_count;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        clear;
      logic        direct;
      logic [3:0]  x;
      logic [3:0]  y;
      logic [7:0]  dindex;
      logic [31:0] color;
      logic        last;
   } emit_type;

   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: OP_PIXEL, sel: 2'd0, endc: END_ALWAYS};
      case (pc)
         3'd0: w = '{op: OP_CLEAR, sel: 2'd0, endc: END_NEVER};
         3'd1: w = '{op: OP_WORD,  sel: 2'd0, endc: END_NEVER};
         3'd2: w = '{op: OP_WORD,  sel: 2'd1, endc: END_NEVER};
         3'd3: w = '{op: OP_WORD,  sel: 2'd2, endc: END_NOHOUR};
         3'd4: w = '{op: OP_HOUR,  sel: 2'd0, endc: END_ALWAYS};
         3'd5: w = '{op: OP_DOTS,  sel: 2'd0, endc: END_ALWAYS};
         3'd6: w = '{op: OP_PIXEL, sel: 2'd0, endc: END_ALWAYS};
         default: w = '{op: OP_PIXEL, sel: 2'd0, endc: END_ALWAYS};
      endcase
      return w;
   endfunction

   function automatic span_type word_span(input logic [1:0] sel);
      span_type s;
      s = '{x: 4'd0, y: 4'd0, len: 4'd1};
      case (sel)
         2'd0: s = '{x: 4'd0, y: 4'd0, len: 4'd2};
         2'd1: s = '{x: 4'd3, y: 4'd0, len: 4'd4};
         2'd2: s = '{x: 4'd8, y: 4'd9, len: 4'd3};
         default: s = '{x: 4'd0, y: 4'd0, len: 4'd1};
      endcase
      return s;
   endfunction

   function automatic span_type hour_span(input logic [3:0] hour);
      span_type s;
      s = '{x: 4'd0, y: 4'd0, len: 4'd1};
      case (hour)
         4'd1:  s = '{x: 4'd0, y: 4'd4, len: 4'd3};
         4'd2:  s = '{x: 4'd3, y: 4'd4, len: 4'd4};
         4'd3:  s = '{x: 4'd8, y: 4'd4, len: 4'd3};
         4'd4:  s = '{x: 4'd0, y: 4'd5, len: 4'd5};
         4'd5:  s = '{x: 4'd5, y: 4'd5, len: 4'd4};
         4'd6:  s = '{x: 4'd0, y: 4'd6, len: 4'd6};
         4'd7:  s = '{x: 4'd6, y: 4'd6, len: 4'd5};
         4'd8:  s = '{x: 4'd0, y: 4'd7, len: 4'd5};
         4'd9:  s = '{x: 4'd5, y: 4'd7, len: 4'd4};
         4'd10: s = '{x: 4'd0, y: 4'd8, len: 4'd4};
         4'd11: s = '{x: 4'd7, y: 4'd8, len: 4'd4};
         4'd12: s = '{x: 4'd0, y: 4'd9, len: 4'd6};
         default: s = '{x: 4'd0, y: 4'd0, len: 4'd1};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/word_clock_pixel_sequencer.sv
`default_nettype none

// channel | ports     | dir | payload
// --------+-----------+-----+-----------------------------------------------
// command | req_*     | in  | tuser func; tdata hour, state_code, col_x,
//         |           |     | row_y, pixel_color
// write   | rsp_*     | out | tuser clear_all; tdata pixel_index, out_color;
//         |           |     | tlast last
// config  | csr_*     | in  | APB registers at byte address 4*i
//
// One write leaves per cycle while the output is not stalled, stepped by the
// microcode step counter into a single output register: show time makes 10 to
// 16 writes, show state 1 to 8, set pixel 1. A command is accepted in the cycle
// after the previous one's last write enters the output register; an unused
// function code is taken and produces nothing. rsp_tready low with a write
// waiting in the output register holds the sequencer in place.
// Reset is synchronous and loads register defaults; no clearing pass.

module word_clock_pixel_sequencer #(
   parameter int WIDTH       = wcps_pkg::WIDTH_DEF,
   parameter int HEIGHT      = wcps_pkg::HEIGHT_DEF,
   parameter int MINUTE_DOTS = wcps_pkg::MINUTE_DOTS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // hour[3:0], state_code[5:4], col_x[9:6], row_y[13:10], pixel_color[45:14]
   input  wire  [47:0]                 req_tdata,
   // func[1:0]
   input  wire  [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // pixel_index[7:0], out_color[39:8]
   output logic [39:0]                 rsp_tdata,
   // clear_all[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire  [wcps_pkg::ADDR_W-1:0] csr_paddr,
   input  wire  [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import wcps_pkg::*;

   cfg_type  cfg;
   emit_type emit;
   logic     take;

   wcps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wcps_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .emit       (emit)
   );

   wcps_dpath #(
      .WIDTH_P       (WIDTH),
      .HEIGHT_P      (HEIGHT),
      .MINUTE_DOTS_P (MINUTE_DOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: rtl/core/wcps_csr.sv
`default_nettype none

module wcps_csr (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_psel,
   input  wire                           csr_penable,
   input  wire                           csr_pwrite,
   input  wire  [wcps_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire  [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output wcps_pkg::cfg_type             cfg
);
   import wcps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_COLOR_ON:      cfg_in.color_on      = csr_pwdata;
            REG_COLOR_STARTUP: cfg_in.color_startup = csr_pwdata;
            REG_COLOR_CONFIG:  cfg_in.color_config  = csr_pwdata;
            REG_COLOR_ERROR:   cfg_in.color_error   = csr_pwdata;
            REG_STATUS_FIRST:  cfg_in.status_first  = csr_pwdata[7:0];
            REG_STATUS_COUNT:  cfg_in.status_count  = csr_pwdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COLOR_ON:      csr_prdata = cfg_ff.color_on;
         REG_COLOR_STARTUP: csr_prdata = cfg_ff.color_startup;
         REG_COLOR_CONFIG:  csr_prdata = cfg_ff.color_config;
         REG_COLOR_ERROR:   csr_prdata = cfg_ff.color_error;
         REG_STATUS_FIRST:  csr_prdata = {24'd0, cfg_ff.status_first};
         REG_STATUS_COUNT:  csr_prdata = {28'd0, cfg_ff.status_count};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_on      <= 32'h00FF_FFFF;
         cfg_ff.color_startup <= 32'h0000_FF00;
         cfg_ff.color_config  <= 32'h0000_00FF;
         cfg_ff.color_error   <= 32'h00FF_0000;
         cfg_ff.status_first  <= 8'd0;
         cfg_ff.status_count  <= 4'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/wcps_useq.sv
`default_nettype none

module wcps_useq (
   input  wire                 clock,
   input  wire                 reset,
   input  wire wcps_pkg::cfg_type cfg,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [47:0]         req_tdata,
   input  wire  [1:0]          req_tuser,
   input  wire                 take,
   output wcps_pkg::emit_type  emit
);
   import wcps_pkg::*;

   logic             busy_ff, busy_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       hour_ff, hour_in;
   logic [1:0]       state_ff, state_in;
   logic [3:0]       colx_ff, colx_in;
   logic [3:0]       rowy_ff, rowy_in;
   logic [31:0]      pcolor_ff, pcolor_in;

   uword_type        uw;
   span_type         sp;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] dots;
   logic [31:0]      dot_color;
   logic             hour_ok;
   logic             step_done;
   logic             end_now;
   logic             req_acc;

   assign req_tready = !busy_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign hour_ok    = (hour_ff >= 4'd1) && (hour_ff <= 4'd12);

   always_comb begin
      case (state_ff)
         ST_STARTUP: begin
            dots      = STARTUP_DOTS;
            dot_color = cfg.color_startup;
         end
         ST_CONFIG: begin
            dots      = CONFIG_DOTS;
            dot_color = cfg.color_config;
         end
         default: begin
            if (cfg.status_count < MIN_DOTS) begin
               dots = MIN_DOTS;
            end else if (cfg.status_count > MAX_DOTS) begin
               dots = MAX_DOTS;
            end else begin
               dots = cfg.status_count;
            end
            dot_color = cfg.color_error;
         end
      endcase
   end

   always_comb begin
      uw          = ucode(pc_ff);
      sp          = '{x: 4'd0, y: 4'd0, len: 4'd1};
      len         = 4'd1;
      emit        = '0;
      case (uw.op)
         OP_CLEAR: begin
            emit.clear = 1'b1;
         end
         OP_WORD: begin
            sp         = word_span(uw.sel);
            len        = sp.len;
            emit.x     = sp.x + 4'(cnt_ff);
            emit.y     = sp.y;
            emit.color = cfg.color_on;
         end
         OP_HOUR: begin
            sp         = hour_span(hour_ff);
            len        = sp.len;
            emit.x     = sp.x + 4'(cnt_ff);
            emit.y     = sp.y;
            emit.color = cfg.color_on;
         end
         OP_DOTS: begin
            len         = dots;
            emit.direct = 1'b1;
            emit.dindex = cfg.status_first + 8'(cnt_ff);
            emit.color  = dot_color;
         end
         OP_PIXEL: begin
            emit.x     = colx_ff;
            emit.y     = rowy_ff;
            emit.color = pcolor_ff;
         end
         default: begin
            emit.clear = 1'b1;
         end
      endcase
      step_done  = ({1'b0, cnt_ff} + 4'd1) == len;
      end_now    = (uw.endc == END_ALWAYS) || ((uw.endc == END_NOHOUR) && !hour_ok);
      emit.valid = busy_ff && take;
      emit.last  = step_done && end_now;
   end

   always_comb begin
      busy_in   = busy_ff;
      pc_in     = pc_ff;
      cnt_in    = cnt_ff;
      hour_in   = hour_ff;
      state_in  = state_ff;
      colx_in   = colx_ff;
      rowy_in   = rowy_ff;
      pcolor_in = pcolor_ff;
      if (emit.valid) begin
         if (step_done) begin
            cnt_in = '0;
            if (end_now) begin
               busy_in = 1'b0;
            end else begin
               pc_in = pc_ff + 3'd1;
            end
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
      if (req_acc) begin
         hour_in   = req_tdata[3:0];
         state_in  = req_tdata[5:4];
         colx_in   = req_tdata[9:6];
         rowy_in   = req_tdata[13:10];
         pcolor_in = req_tdata[45:14];
         cnt_in    = '0;
         case (req_tuser)
            FUNC_TIME: begin
               busy_in = 1'b1;
               pc_in   = PC_TIME;
            end
            FUNC_STATE: begin
               busy_in = 1'b1;
               pc_in   = PC_DOTS;
            end
            FUNC_PIXEL: begin
               busy_in = 1'b1;
               pc_in   = PC_PIXEL;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_TIME;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hour_ff   <= hour_in;
      state_ff  <= state_in;
      colx_ff   <= colx_in;
      rowy_ff   <= rowy_in;
      pcolor_ff <= pcolor_in;
   end

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !busy_in |-> emit.valid && emit.last)
      else $error("sequencer left a command without a last transfer");

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser != FUNC_UNUSED) |=> busy_ff && (cnt_ff == '0))
      else $error("command accepted but program not started");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, cnt_ff} < len))
      else $error("element counter ran past step length");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= PC_PIXEL))
      else $error("step counter outside program");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !take |=> $stable(pc_ff) && $stable(cnt_ff))
      else $error("sequencer advanced while output stalled");

endmodule

`default_nettype wire

FILE: rtl/core/wcps_dpath.sv
`default_nettype none

module wcps_dpath #(
   parameter int WIDTH_P       = wcps_pkg::WIDTH_DEF,
   parameter int HEIGHT_P      = wcps_pkg::HEIGHT_DEF,
   parameter int MINUTE_DOTS_P = wcps_pkg::MINUTE_DOTS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire wcps_pkg::emit_type emit,
   output logic                take,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);
   import wcps_pkg::*;

   logic        valid_ff, valid_in;
   logic        clear_ff, clear_in;
   logic [7:0]  index_ff, index_in;
   logic [31:0] color_ff, color_in;
   logic        last_ff, last_in;

   logic [7:0]  rows_below;
   logic [7:0]  row_base;
   logic [7:0]  col;
   logic [7:0]  mapped;

   assign take = !valid_ff || rsp_tready;

   always_comb begin
      rows_below = 8'(HEIGHT_P - 1) - {4'd0, emit.y};
      row_base   = 8'(rows_below * 8'(WIDTH_P));
      col        = emit.y[0] ? (8'(WIDTH_P - 1) - {4'd0, emit.x}) : {4'd0, emit.x};
      if ({1'b0, emit.y} < 5'(HEIGHT_P)) begin
         mapped = row_base + col + 8'(MINUTE_DOTS_P);
      end else begin
         mapped = {4'd0, emit.x};
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      clear_in = clear_ff;
      index_in = index_ff;
      color_in = color_ff;
      last_in  = last_ff;
      if (emit.valid) begin
         valid_in = 1'b1;
         clear_in = emit.clear;
         last_in  = emit.last;
         if (emit.clear) begin
            index_in = 8'd0;
            color_in = 32'd0;
         end else begin
            index_in = emit.direct ? emit.dindex : mapped;
            color_in = emit.color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clear_ff <= clear_in;
      index_ff <= index_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {color_ff, index_ff};
   assign rsp_tuser  = clear_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire
